/* src/mlp_pkg.sv */
// Shared types, codes and the sigmoid sample function for the perceptron engine.
package mlp_pkg;

  localparam logic [2:0] MODE_HW   = 3'd0;
  localparam logic [2:0] MODE_HB   = 3'd1;
  localparam logic [2:0] MODE_OW   = 3'd2;
  localparam logic [2:0] MODE_OB   = 3'd3;
  localparam logic [2:0] MODE_FEAT = 3'd4;

  localparam logic [1:0] REG_INPUTS  = 2'd0;
  localparam logic [1:0] REG_HIDDEN  = 2'd1;
  localparam logic [1:0] REG_OUTPUTS = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIAS,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_INDEX,
    ST_LOOKUP,
    ST_STORE
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic init;
    logic en;
  } mac_ctrl_t;

  // shift-subtract quotient of n by d; elaboration-time only
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sigmoid of a/4096 for a >= 0, Q0.12; elaboration-time only
  function automatic logic [12:0] sig_positive(input int a);
    longint unsigned y;
    longint unsigned term;
    longint          sum;
    longint unsigned e;
    longint unsigned den;
    longint unsigned res;
    y    = longint'(a) << 14;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (int i = 1; i <= 10; i++) begin
      term = udiv((term * y) >> 30, longint'(i));
      if (i[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    e = longint'(sum);
    for (int i = 0; i < 4; i++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    den = (64'd1 << 30) + e;
    res = udiv((64'd1 << 42) + (den >> 1), den);
    return res[12:0];
  endfunction

endpackage

/* src/mlp_cell.sv */
// One register cell of an operand ring: loads by index, else shifts from its neighbor.
module mlp_cell #(
  parameter int W   = 16,
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  mlp_pkg::cell_ctrl_t ctrl,
  input  logic [IW-1:0]       load_idx,
  input  logic [W-1:0]        load_val,
  input  logic [W-1:0]        shift_in,
  output logic [W-1:0]        q
);

  always_ff @(posedge clk) begin
    if (ctrl.load && load_idx == IW'(IDX)) begin
      q <= load_val;
    end else if (ctrl.shift) begin
      q <= shift_in;
    end
  end

endmodule

/* src/mlp_mac.sv */
// Multiply-accumulate unit: registered product, then wide accumulator.
module mlp_mac #(
  parameter int ACC_W = 38
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mlp_pkg::mac_ctrl_t      ctrl,
  input  logic signed [15:0]      bias,
  input  logic signed [15:0]      w,
  input  logic signed [16:0]      x,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [32:0] prod;
  logic               en_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      en_q <= 1'b0;
    end else begin
      en_q <= ctrl.en;
    end
  end

  always_ff @(posedge clk) begin
    prod <= w * x;
    if (ctrl.init) begin
      acc <= {{(ACC_W-28){bias[15]}}, bias, 12'b0};
    end else if (en_q) begin
      acc <= acc + {{(ACC_W-33){prod[32]}}, prod};
    end
  end

endmodule

/* src/mlp_two_layer_sigmoid_inference.sv */
// Top level: two-layer perceptron inference with operand rings and one shared MAC.
// Run: a last feature beat starts a run over the nh hidden and then the no output neurons
//   (nh, no = hidden and output counts in use); results leave one per output neuron.
// Throughput: one beat per cycle while idle; no beat is taken during a run. The single
//   MAC walks every weight slot of a row, one slot per cycle, as the operand ring turns.
// Reset: rst clears control and sets the counts to 2/4/1; weight, bias and feature
//   stores are undefined until written and are never cleared.
module mlp_two_layer_sigmoid_inference #(
  parameter int MAX_INPUTS          = 16,
  parameter int MAX_HIDDEN          = 16,
  parameter int MAX_OUTPUTS         = 8,
  parameter int SIGMOID_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // row[3:0], col[7:4], value[23:8]
  input  logic [2:0]  s_tuser,   // mode[2:0]
  input  logic        s_tlast,   // last feature of a vector
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_index[2:0], out_value[15:3]
  output logic        m_tlast    // result of the final output neuron
);

  localparam int MAXIH = (MAX_INPUTS > MAX_HIDDEN) ? MAX_INPUTS : MAX_HIDDEN;
  localparam int MAXHO = (MAX_HIDDEN > MAX_OUTPUTS) ? MAX_HIDDEN : MAX_OUTPUTS;
  localparam int OMAX  = (MAX_OUTPUTS < 8) ? MAX_OUTPUTS : 8;
  localparam int FIW   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int HIW   = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int OIW   = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int HWD   = MAX_HIDDEN * MAX_INPUTS;
  localparam int OWD   = MAX_OUTPUTS * MAX_HIDDEN;
  localparam int HAW   = (HWD > 1) ? $clog2(HWD) : 1;
  localparam int OAW   = (OWD > 1) ? $clog2(OWD) : 1;
  localparam int AW    = (HAW > OAW) ? HAW : OAW;
  localparam int SW    = $clog2(MAXIH + 1);
  localparam int NW    = $clog2(MAXHO + 1);
  localparam int ACC_W = 33 + $clog2(MAXIH + 1);
  localparam int XW    = (SIGMOID_TABLE_DEPTH > 1) ? $clog2(SIGMOID_TABLE_DEPTH) : 1;
  localparam logic signed [ACC_W-1:0] LIM = ACC_W'(134217728);

  // beat fields
  logic [2:0]         mode;
  logic [3:0]         row;
  logic [3:0]         col;
  logic signed [15:0] value;
  logic               in_acc;

  assign mode   = s_tuser;
  assign row    = s_tdata[3:0];
  assign col    = s_tdata[7:4];
  assign value  = s_tdata[23:8];
  assign in_acc = s_tvalid && s_tready;

  // configuration
  logic [4:0] input_count;
  logic [4:0] hidden_count;
  logic [3:0] output_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_count  <= 5'd2;
      hidden_count <= 5'd4;
      output_count <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mlp_pkg::REG_INPUTS:  input_count  <= cfg_data;
        mlp_pkg::REG_HIDDEN:  hidden_count <= cfg_data;
        mlp_pkg::REG_OUTPUTS: output_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // counts in use, clamped to the store sizes
  logic [4:0] ni;
  logic [4:0] nh;
  logic [3:0] no;

  assign ni = (32'(input_count) > MAX_INPUTS) ? 5'(MAX_INPUTS) : input_count;
  assign nh = (32'(hidden_count) > MAX_HIDDEN) ? 5'(MAX_HIDDEN) : hidden_count;
  assign no = (32'(output_count) > OMAX) ? 4'(OMAX) : output_count;

  // control registers
  mlp_pkg::state_t state, state_next;
  logic            layer;     // 0 hidden, 1 output
  logic [NW-1:0]   neuron;
  logic [SW-1:0]   step;
  logic [AW-1:0]   waddr;
  logic            dcnt;

  logic start_ok;
  logic step_last;
  logic step_en;
  logic neuron_last;
  logic out_free;

  assign start_ok    = in_acc && mode == mlp_pkg::MODE_FEAT && s_tlast &&
                       (nh != 5'd0 || no != 4'd0);
  assign step_last   = layer ? (32'(step) == MAX_HIDDEN - 1) : (32'(step) == MAX_INPUTS - 1);
  assign step_en     = layer ? (32'(step) < 32'(nh)) : (32'(step) < 32'(ni));
  assign neuron_last = layer ? (32'(neuron) + 1 == 32'(no)) : (32'(neuron) + 1 == 32'(nh));
  assign out_free    = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mlp_pkg::ST_IDLE:   if (start_ok) state_next = mlp_pkg::ST_BIAS;
      mlp_pkg::ST_BIAS:   state_next = mlp_pkg::ST_MAC;
      mlp_pkg::ST_MAC:    if (step_last) state_next = mlp_pkg::ST_DRAIN;
      mlp_pkg::ST_DRAIN:  if (dcnt) state_next = mlp_pkg::ST_ROUND;
      mlp_pkg::ST_ROUND:  state_next = mlp_pkg::ST_INDEX;
      mlp_pkg::ST_INDEX:  state_next = mlp_pkg::ST_LOOKUP;
      mlp_pkg::ST_LOOKUP: state_next = mlp_pkg::ST_STORE;
      mlp_pkg::ST_STORE: begin
        if (!layer) begin
          if (!neuron_last) begin
            state_next = mlp_pkg::ST_BIAS;
          end else if (no != 4'd0) begin
            state_next = mlp_pkg::ST_BIAS;
          end else begin
            state_next = mlp_pkg::ST_IDLE;
          end
        end else if (out_free) begin
          state_next = neuron_last ? mlp_pkg::ST_IDLE : mlp_pkg::ST_BIAS;
        end
      end
      default: state_next = mlp_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  mlp_pkg::cell_ctrl_t fctrl;
  mlp_pkg::cell_ctrl_t hctrl;
  mlp_pkg::mac_ctrl_t  mctrl;
  logic                mac_step;
  logic                emit;

  always_comb begin
    s_tready    = (state == mlp_pkg::ST_IDLE);
    mac_step    = (state == mlp_pkg::ST_MAC);
    fctrl.load  = in_acc && mode == mlp_pkg::MODE_FEAT && 32'(col) < MAX_INPUTS;
    fctrl.shift = mac_step && !layer;
    hctrl.load  = (state == mlp_pkg::ST_STORE) && !layer;
    hctrl.shift = mac_step && layer;
    mctrl.init  = mac_step && step == '0;
    mctrl.en    = 1'b0;
    emit        = (state == mlp_pkg::ST_STORE) && layer && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mlp_pkg::ST_IDLE;
      layer  <= 1'b0;
      neuron <= '0;
      step   <= '0;
      waddr  <= '0;
      dcnt   <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        mlp_pkg::ST_IDLE: begin
          layer  <= (nh == 5'd0);
          neuron <= '0;
          step   <= '0;
          waddr  <= '0;
        end
        mlp_pkg::ST_MAC: begin
          step  <= step_last ? '0 : step + 1'b1;
          waddr <= waddr + 1'b1;
          dcnt  <= 1'b0;
        end
        mlp_pkg::ST_DRAIN: dcnt <= 1'b1;
        mlp_pkg::ST_STORE: begin
          if (!layer) begin
            if (neuron_last) begin
              // hidden layer done: output rows start at weight slot zero
              layer  <= 1'b1;
              neuron <= '0;
              waddr  <= '0;
            end else begin
              neuron <= neuron + 1'b1;
            end
          end else if (out_free) begin
            neuron <= neuron + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // weight and bias stores
  logic signed [15:0] hw_mem [HWD];
  logic signed [15:0] ow_mem [OWD];
  logic signed [15:0] hb_mem [MAX_HIDDEN];
  logic signed [15:0] ob_mem [MAX_OUTPUTS];
  logic signed [15:0] hw_q;
  logic signed [15:0] ow_q;
  logic signed [15:0] hb_q;
  logic signed [15:0] ob_q;

  always_ff @(posedge clk) begin
    if (in_acc && mode == mlp_pkg::MODE_HW && 32'(row) < MAX_HIDDEN &&
        32'(col) < MAX_INPUTS) begin
      hw_mem[HAW'(32'(row) * MAX_INPUTS + 32'(col))] <= value;
    end
    hw_q <= hw_mem[HAW'(waddr)];
  end

  always_ff @(posedge clk) begin
    if (in_acc && mode == mlp_pkg::MODE_OW && 32'(row) < MAX_OUTPUTS &&
        32'(col) < MAX_HIDDEN) begin
      ow_mem[OAW'(32'(row) * MAX_HIDDEN + 32'(col))] <= value;
    end
    ow_q <= ow_mem[OAW'(waddr)];
  end

  always_ff @(posedge clk) begin
    if (in_acc && mode == mlp_pkg::MODE_HB && 32'(row) < MAX_HIDDEN) begin
      hb_mem[HIW'(row)] <= value;
    end
    hb_q <= hb_mem[HIW'(neuron)];
  end

  always_ff @(posedge clk) begin
    if (in_acc && mode == mlp_pkg::MODE_OB && 32'(row) < MAX_OUTPUTS) begin
      ob_mem[OIW'(row)] <= value;
    end
    ob_q <= ob_mem[OIW'(neuron)];
  end

  // operand rings: the head cell always holds the operand for the current slot
  logic [15:0] fring [MAX_INPUTS];
  logic [12:0] hring [MAX_HIDDEN];
  logic [12:0] sig;

  for (genvar k = 0; k < MAX_INPUTS; k++) begin : g_fcell
    mlp_cell #(.W(16), .IW(FIW), .IDX(k)) u_cell (
      .clk      (clk),
      .ctrl     (fctrl),
      .load_idx (FIW'(col)),
      .load_val (value),
      .shift_in (fring[(k + 1) % MAX_INPUTS]),
      .q        (fring[k])
    );
  end

  for (genvar k = 0; k < MAX_HIDDEN; k++) begin : g_hcell
    mlp_cell #(.W(13), .IW(HIW), .IDX(k)) u_cell (
      .clk      (clk),
      .ctrl     (hctrl),
      .load_idx (HIW'(neuron)),
      .load_val (sig),
      .shift_in (hring[(k + 1) % MAX_HIDDEN]),
      .q        (hring[k])
    );
  end

  // operand stage aligned with the registered weight read
  logic signed [16:0] opnd_q;
  logic               en1;
  logic               layer_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      en1 <= 1'b0;
    end else begin
      en1 <= mac_step && step_en;
    end
  end

  always_ff @(posedge clk) begin
    layer_q <= layer;
    opnd_q  <= layer ? {4'b0, hring[0]} : {fring[0][15], fring[0]};
  end

  mlp_pkg::mac_ctrl_t  mctrl_pipe;
  logic signed [ACC_W-1:0] acc;

  assign mctrl_pipe.init = mctrl.init;
  assign mctrl_pipe.en   = en1 | mctrl.en;

  mlp_mac #(.ACC_W(ACC_W)) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mctrl_pipe),
    .bias (layer ? ob_q : hb_q),
    .w    (layer_q ? ow_q : hw_q),
    .x    (opnd_q),
    .acc  (acc)
  );

  // round, saturate to Q4.12, index the table
  logic signed [ACC_W-1:0] rnd;
  logic signed [15:0]      qv;
  logic [XW-1:0]           idx;
  logic [31:0]             scaled;

  assign rnd    = acc + ACC_W'(2048);
  assign scaled = 32'({~qv[15], qv[14:0]}) * 32'(SIGMOID_TABLE_DEPTH);

  // sigmoid samples, one per table entry, fixed at elaboration
  logic [12:0] sig_rom [SIGMOID_TABLE_DEPTH];

  for (genvar g = 0; g < SIGMOID_TABLE_DEPTH; g++) begin : g_rom
    localparam int S = ((2 * g + 1) * 32768) / SIGMOID_TABLE_DEPTH - 32768;
    localparam logic [12:0] E = (S >= 0) ? mlp_pkg::sig_positive(S)
                                         : 13'(4096 - int'(mlp_pkg::sig_positive(-S)));
    assign sig_rom[g] = E;
  end

  always_ff @(posedge clk) begin
    if (state == mlp_pkg::ST_ROUND) begin
      if (rnd >= LIM) begin
        qv <= 16'sh7FFF;
      end else if (rnd < -LIM) begin
        qv <= -16'sh8000;
      end else begin
        qv <= rnd[27:12];
      end
    end
    if (state == mlp_pkg::ST_INDEX) begin
      idx <= XW'(scaled >> 16);
    end
    if (state == mlp_pkg::ST_LOOKUP) begin
      sig <= sig_rom[idx];
    end
  end

  // result register: holds a beat while the next neuron is worked on
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {sig, 3'(neuron)};
      m_tlast <= neuron_last;
    end
  end

`ifndef SYNTHESIS
  // no input beat is taken during a run
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    state != mlp_pkg::ST_IDLE |-> !s_tready)
    else $error("input accepted while busy");

  // a waiting result is never overwritten
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("pending result lost");

  // the final result carries the last output index in use
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    emit && neuron_last |-> 32'(neuron) + 1 == 32'(no))
    else $error("final result index mismatch");
`endif

endmodule
